// ----- rtl/core/fbrq_pkg.sv -----
// ----------------------------------------------------------------------------
// fbrq_pkg
// Shared types, codes and constants of the framed byte ring queue.
// ----------------------------------------------------------------------------
package fbrq_pkg;

  // Ring geometry.
  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  // Room check sums a used count, an 8-bit size and a small constant.
  localparam int SUM_W       = 10;
  localparam int MAX_DRAIN   = 64;
  localparam int CNT_W       = 7;

  // Register reset values.
  localparam logic [7:0] RST_LOCAL_START = 8'd128;
  localparam logic [7:0] RST_LOCAL_END   = 8'd175;
  localparam logic [7:0] RST_UNRELIABLE  = 8'd240;
  localparam logic [7:0] RST_INVALID_TAG = 8'd255;
  localparam logic [7:0] RST_MAX_MSG     = 8'd127;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LOCAL_START = 3'd0,
    REG_LOCAL_END   = 3'd1,
    REG_UNRELIABLE  = 3'd2,
    REG_INVALID_TAG = 3'd3,
    REG_MAX_MSG     = 3'd4
  } reg_idx_t;

  // Item kinds.
  typedef enum logic [1:0] {
    FUNC_HEADER  = 2'd0,
    FUNC_PAYLOAD = 2'd1,
    FUNC_DRAIN   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Result codes.
  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_DROPPED   = 4'd1,
    ST_WAIT      = 4'd2,
    ST_SELF      = 4'd3,
    ST_TOO_BIG   = 4'd4,
    ST_SIDE      = 4'd5,
    ST_STORED    = 4'd6,
    ST_DISCARDED = 4'd7,
    ST_DRAINED   = 4'd8,
    ST_EMPTY     = 4'd9
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;   // latch the accepted input beat
    logic    abandon;   // drop the open message
    logic    put_len;   // write the length byte
    logic    put_id;    // write the id byte and open or publish the message
    logic    put_byte;  // write one payload byte
    logic    rd;        // read the ring at the read pointer, or one ahead on a pop
    logic    pop;       // advance the read pointer and drain count
    logic    load;      // load the result register
    status_t code;
    logic    use_rdata;
    logic    last;
  } fbrq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  storing;
    logic  tag_side;
    logic  tag_self;
    logic  too_big;
    logic  no_room;
    logic  unreliable;
    logic  ring_empty;
    logic  count_zero;
    logic  pop_last;
    logic  out_free;
  } fbrq_sts_t;

  // Advance a ring pointer with wrap.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/fbrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbrq_ctrl
// Controller state machine: sequences header, payload and drain items.
// ----------------------------------------------------------------------------
module fbrq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fbrq_pkg::fbrq_sts_t sts,
  output fbrq_pkg::fbrq_cmd_t cmd
);
  import fbrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HDR_ID,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  // Only an idle controller takes a new beat.
  assign in_ready = (state == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    cmd.code   = ST_EMPTY;
    cmd.last   = 1'b1;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.func)
          FUNC_HEADER: begin
            if (sts.out_free) begin
              cmd.abandon = sts.storing;
              priority if (sts.tag_side) begin
                cmd.load   = 1'b1;
                cmd.code   = ST_SIDE;
                state_next = S_IDLE;
              end else if (sts.tag_self) begin
                cmd.load   = 1'b1;
                cmd.code   = ST_SELF;
                state_next = S_IDLE;
              end else if (sts.too_big) begin
                cmd.load   = 1'b1;
                cmd.code   = ST_TOO_BIG;
                state_next = S_IDLE;
              end else if (sts.no_room) begin
                cmd.load   = 1'b1;
                cmd.code   = sts.unreliable ? ST_DROPPED : ST_WAIT;
                state_next = S_IDLE;
              end else begin
                cmd.put_len = 1'b1;
                state_next  = S_HDR_ID;
              end
            end
          end
          FUNC_PAYLOAD: begin
            if (sts.out_free) begin
              cmd.load     = 1'b1;
              cmd.put_byte = sts.storing;
              cmd.code     = sts.storing ? ST_STORED : ST_DISCARDED;
              state_next   = S_IDLE;
            end
          end
          FUNC_DRAIN: begin
            if (sts.count_zero || sts.ring_empty) begin
              if (sts.out_free) begin
                cmd.load   = 1'b1;
                cmd.code   = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd     = 1'b1;
              state_next = S_DRAIN;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_HDR_ID: begin
        if (sts.out_free) begin
          cmd.put_id = 1'b1;
          cmd.load   = 1'b1;
          cmd.code   = ST_ACCEPTED;
          state_next = S_IDLE;
        end
      end
      S_DRAIN: begin
        // Emit the byte last read into rdata and, unless it is the last, fetch the one after it.
        if (sts.out_free) begin
          cmd.load      = 1'b1;
          cmd.code      = ST_DRAINED;
          cmd.use_rdata = 1'b1;
          cmd.last      = sts.pop_last;
          cmd.pop       = 1'b1;
          if (sts.pop_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/fbrq_dp.sv -----
// ----------------------------------------------------------------------------
// fbrq_dp
// Datapath: registers, ring memory, pointers, classification and result
// register.
// ----------------------------------------------------------------------------
module fbrq_dp (
  input  logic                clk,
  input  logic                rst,
  // Configuration writes
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  // Captured input beat
  input  logic [1:0]          in_func,
  input  logic [39:0]         in_data,
  // Controller link
  input  fbrq_pkg::fbrq_cmd_t cmd,
  output fbrq_pkg::fbrq_sts_t sts,
  // Result register
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_status,
  output logic [7:0]          out_data,
  output logic                out_last
);
  import fbrq_pkg::*;

  // Configuration registers.
  logic [7:0] local_start;
  logic [7:0] local_end;
  logic [7:0] unreliable_from;
  logic [7:0] invalid_tag;
  logic [7:0] max_msg;

  // Captured item.
  func_t      func;
  logic [7:0] msg_size;
  logic [7:0] msg_id;
  logic [7:0] route_byte;
  logic [7:0] data_byte;
  logic [CNT_W-1:0] count;

  // Ring state.
  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       rdata;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] cp;
  logic [PTR_W-1:0] rp;
  logic [7:0]       payload_left;
  logic             storing;

  logic [PTR_W-1:0] eff_wp;
  logic [PTR_W-1:0] rp_next;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       wr_val;
  logic             wr_en;
  logic [7:0]       tag;
  logic [SUM_W-1:0] used;
  logic [SUM_W-1:0] need;
  logic [CNT_W-1:0] req_len;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_start     <= RST_LOCAL_START;
      local_end       <= RST_LOCAL_END;
      unreliable_from <= RST_UNRELIABLE;
      invalid_tag     <= RST_INVALID_TAG;
      max_msg         <= RST_MAX_MSG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_START: local_start     <= cfg_data;
        REG_LOCAL_END:   local_end       <= cfg_data;
        REG_UNRELIABLE:  unreliable_from <= cfg_data;
        REG_INVALID_TAG: invalid_tag     <= cfg_data;
        REG_MAX_MSG:     max_msg         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drain length is limited to the largest burst.
  assign req_len = (in_data[38:32] > CNT_W'(MAX_DRAIN)) ? CNT_W'(MAX_DRAIN) : in_data[38:32];

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func       <= func_t'(in_func);
      msg_size   <= in_data[7:0];
      msg_id     <= in_data[15:8];
      route_byte <= in_data[23:16];
      data_byte  <= in_data[31:24];
    end
  end

  // Drain count.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count <= req_len;
    end else if (cmd.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // An open message is abandoned before a new header is judged.
  assign eff_wp  = storing ? cp : wp;
  assign rp_next = ring_next(rp);

  // Header classification.
  assign tag  = (msg_id == invalid_tag) ? route_byte : msg_id;
  assign used = (eff_wp >= rp) ? SUM_W'(eff_wp - rp)
                               : SUM_W'(eff_wp) + SUM_W'(QUEUE_DEPTH) - SUM_W'(rp);
  assign need = used + SUM_W'(msg_size) + SUM_W'(3);

  always_comb begin
    sts            = '0;
    sts.func       = func;
    sts.storing    = storing;
    sts.tag_side   = (tag < local_start);
    sts.tag_self   = (tag <= local_end);
    sts.too_big    = ({1'b0, msg_size} + 9'd1) > {1'b0, max_msg};
    sts.no_room    = (need > SUM_W'(QUEUE_DEPTH));
    sts.unreliable = (msg_id >= unreliable_from);
    sts.ring_empty = (rp == cp);
    sts.count_zero = (count == '0);
    sts.pop_last   = (count == CNT_W'(1)) || (rp_next == cp);
    sts.out_free   = !out_valid || out_ready;
  end

  // Ring write port.
  always_comb begin
    wr_en   = cmd.put_len || cmd.put_id || cmd.put_byte;
    wr_addr = cmd.put_len ? eff_wp : wp;
    wr_val  = data_byte;
    if (cmd.put_len) begin
      wr_val = msg_size + 8'd1;
    end else if (cmd.put_id) begin
      wr_val = msg_id;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
  end

  // Ring read port; a pop in the same cycle reads ahead.
  assign rd_addr = cmd.pop ? rp_next : rp;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // Pointer and message tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      cp           <= '0;
      rp           <= '0;
      payload_left <= '0;
      storing      <= 1'b0;
    end else begin
      if (cmd.abandon) begin
        wp           <= cp;
        storing      <= 1'b0;
        payload_left <= '0;
      end
      if (cmd.put_len) begin
        wp <= ring_next(eff_wp);
      end
      if (cmd.put_id) begin
        wp <= ring_next(wp);
        if (msg_size == 8'd0) begin
          cp <= ring_next(wp);
        end else begin
          payload_left <= msg_size;
          storing      <= 1'b1;
        end
      end
      if (cmd.put_byte) begin
        wp           <= ring_next(wp);
        payload_left <= payload_left - 8'd1;
        if (payload_left == 8'd1) begin
          storing <= 1'b0;
          cp      <= ring_next(wp);
        end
      end
      if (cmd.pop) begin
        rp <= rp_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= cmd.code;
      out_data   <= cmd.use_rdata ? rdata : 8'd0;
      out_last   <= cmd.last;
    end
  end

endmodule

// ----- rtl/core/framed_byte_ring_queue.sv -----
// ----------------------------------------------------------------------------
// framed_byte_ring_queue
// Outbound message queue with tag routing over a 256-byte ring.
// ----------------------------------------------------------------------------
// Each input beat is one item: a header, a payload byte or a drain request,
// selected by s_tuser. Headers are routed by tag and, when accepted, store a
// length byte and the id; payload bytes follow one beat each and a message is
// visible to drains only after its last byte. One item is worked at a time.
// An accepted header writes its length and id bytes in separate states, as they
// share the single ring write port; a drain emits its bytes one at a time, the
// ring read data being registered. Every result leaves through a result
// register, so a stalled sink holds the queue only once the next result is
// ready. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module framed_byte_ring_queue (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // msg_size[7:0], msg_id[15:8], route_byte[23:16], data_byte[31:24],
  // max_length[38:32], zero[39]
  input  logic [39:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_out[7:0]
  output logic [7:0]  m_tdata,
  // status[3:0]
  output logic [3:0]  m_tuser,
  output logic        m_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fbrq_pkg::*;

  fbrq_cmd_t cmd;
  fbrq_sts_t sts;

  assign cfg_ready = 1'b1;

  fbrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbrq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_func    (s_tuser),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- dv/fbrq_checker.sv -----
// ----------------------------------------------------------------------------
// fbrq_checker
// Watches the item, result and register channels of the framed byte ring
// queue. It keeps its own copy of the ring, pointers and registers, works out
// the results of every accepted item and compares each result beat, in order,
// with the oldest result still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbrq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic [3:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import fbrq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Results owed by the block, oldest first.
  result_t          owed_results[$];

  // Shadow ring and message framing state.
  logic [7:0]       ring_bytes[QUEUE_DEPTH];
  logic [PTR_W-1:0] head_wr;
  logic [PTR_W-1:0] head_commit;
  logic [PTR_W-1:0] head_rd;
  int               bytes_left;
  logic             msg_open;

  // Shadow registers.
  logic [7:0]       tag_lo;
  logic [7:0]       tag_hi;
  logic [7:0]       unrel_id;
  logic [7:0]       relay_id;
  logic [7:0]       size_cap;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
  endfunction

  function automatic void ring_write(input logic [7:0] v);
    ring_bytes[head_wr] = v;
    head_wr = advance(head_wr);
  endfunction

  // Routes a header and, when it fits, writes the length and id bytes.
  function automatic status_t route_header(input logic [7:0] size,
                                           input logic [7:0] id,
                                           input logic [7:0] route);
    logic [7:0] tag;
    int         room;
    // A new header drops whatever message is still waiting for bytes.
    if (msg_open) begin
      head_wr    = head_commit;
      msg_open   = 1'b0;
      bytes_left = 0;
    end
    tag = (id == relay_id) ? route : id;
    if (tag < tag_lo) return ST_SIDE;
    if (tag <= tag_hi) return ST_SELF;
    if (int'(size) + 1 > int'(size_cap)) return ST_TOO_BIG;
    room = QUEUE_DEPTH - int'(PTR_W'(head_wr - head_rd));
    if (room < int'(size) + 3) return (id >= unrel_id) ? ST_DROPPED : ST_WAIT;
    ring_write(8'(int'(size) + 1));
    ring_write(id);
    if (size == 8'd0) begin
      head_commit = head_wr;
    end else begin
      bytes_left = int'(size);
      msg_open   = 1'b1;
    end
    return ST_ACCEPTED;
  endfunction

  // Stores one payload byte; the message is published with its last byte.
  function automatic status_t store_payload(input logic [7:0] b);
    if (!msg_open) return ST_DISCARDED;
    ring_write(b);
    bytes_left--;
    if (bytes_left == 0) begin
      msg_open    = 1'b0;
      head_commit = head_wr;
    end
    return ST_STORED;
  endfunction

  // Queues the bytes a drain takes out, or a single empty result.
  function automatic void drain_ring(input logic [6:0] want);
    int      lim;
    int      n;
    result_t r;
    lim = (int'(want) > MAX_DRAIN) ? MAX_DRAIN : int'(want);
    n   = 0;
    while (head_rd != head_commit && n < lim) begin
      r.status = ST_DRAINED;
      r.data   = ring_bytes[head_rd];
      head_rd  = advance(head_rd);
      n++;
      r.last   = (head_rd == head_commit) || (n == lim);
      owed_results.push_back(r);
    end
    if (n == 0) begin
      r.status = ST_EMPTY;
      r.data   = '0;
      r.last   = 1'b1;
      owed_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t entry;
    if (rst) begin
      owed_results.delete();
      head_wr     = '0;
      head_commit = '0;
      head_rd     = '0;
      bytes_left  = 0;
      msg_open    = 1'b0;
      tag_lo      = RST_LOCAL_START;
      tag_hi      = RST_LOCAL_END;
      unrel_id    = RST_UNRELIABLE;
      relay_id    = RST_INVALID_TAG;
      size_cap    = RST_MAX_MSG;
      errors      = 0;
    end else begin
      // Register writes; indexes past the last register are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOCAL_START: tag_lo = cfg_data;
          REG_LOCAL_END:   tag_hi = cfg_data;
          REG_UNRELIABLE:  unrel_id = cfg_data;
          REG_INVALID_TAG: relay_id = cfg_data;
          REG_MAX_MSG:     size_cap = cfg_data;
          default: ;
        endcase
      end

      // Accepted item: work out what it owes.
      if (s_tvalid && s_tready) begin
        entry.data = '0;
        entry.last = 1'b1;
        case (s_tuser)
          FUNC_HEADER: begin
            entry.status = route_header(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
            owed_results.push_back(entry);
          end
          FUNC_PAYLOAD: begin
            entry.status = store_payload(s_tdata[31:24]);
            owed_results.push_back(entry);
          end
          FUNC_DRAIN: drain_ring(s_tdata[38:32]);
          default: ;  // the unused code owes nothing
        endcase
      end

      // Result beat: compare with the oldest owed result.
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: unexpected result beat: status %0d data %02h last %0b",
                     $realtime, m_tuser, m_tdata, m_tlast);
          errors++;
        end else begin
          entry = owed_results.pop_front();
          if (m_tuser !== entry.status || m_tdata !== entry.data ||
              m_tlast !== entry.last) begin
            if (errors < REPORT_LIMIT)
              $display("%0t: result mismatch: status %0d (exp %0d) data %02h (exp %02h) last %0b (exp %0b)",
                       $realtime, m_tuser, entry.status, m_tdata, entry.data,
                       m_tlast, entry.last);
            errors++;
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

// ----- dv/tb_framed_byte_ring_queue.sv -----
// ----------------------------------------------------------------------------
// tb_framed_byte_ring_queue
// Stimulus and verdict for the framed byte ring queue.
// ----------------------------------------------------------------------------
// A directed opening covers empty drains, stray bytes, the unused item kind,
// every routing outcome but a full ring, message abandon and the drain length
// clamp. Random phases under several register settings then send framed
// messages with random content, mixed with drains, broken frames and noise.
// One long stall of the result side backs the queue up into its input. A
// checker module beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_framed_byte_ring_queue;
  import fbrq_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;   // index past the last register
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 100;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          errors;
  int          pending;

  bit          quiet;          // no idling on either side
  bit          hold_req;       // asks the result side for one long stall
  int          sender_steady;  // beats left in a stretch without gaps
  logic [7:0]  cfg_mirror[0:4];

  framed_byte_ring_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fbrq_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // One input beat. Called at a falling edge; returns at the falling edge
  // after acceptance with tvalid still high, so back-to-back beats never dip.
  task automatic send_item(input func_t f, input logic [7:0] size,
                           input logic [7:0] id, input logic [7:0] route,
                           input logic [7:0] dbyte, input logic [6:0] mlen);
    int gap;
    gap = 0;
    if (!quiet) begin
      if (sender_steady > 0) begin
        sender_steady--;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
      end else if ($urandom_range(0, 29) == 0) begin
        sender_steady = $urandom_range(10, 60);
      end
    end
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = f;
    s_tdata  = {1'b0, mlen, dbyte, route, id, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] size, input logic [7:0] id,
                             input logic [7:0] route);
    send_item(FUNC_HEADER, size, id, route, rnd8(), 7'($urandom_range(0, 127)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(FUNC_PAYLOAD, rnd8(), rnd8(), rnd8(), b, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_drain(input logic [6:0] mlen);
    send_item(FUNC_DRAIN, rnd8(), rnd8(), rnd8(), rnd8(), mlen);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx <= REG_MAX_MSG) cfg_mirror[idx] = val;
  endtask

  task automatic load_regs(input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] unrel, input logic [7:0] relay,
                           input logic [7:0] cap);
    write_reg(REG_LOCAL_START, lo);
    write_reg(REG_LOCAL_END, hi);
    write_reg(REG_UNRELIABLE, unrel);
    write_reg(REG_INVALID_TAG, relay);
    write_reg(REG_MAX_MSG, cap);
  endtask

  // Waits until every owed result is out and the block has gone quiet.
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random traffic: mostly framed messages whose tags and sizes are steered
  // by the current register values, plus drains, stray bytes and noise.
  task automatic run_traffic(input int budget, input int drain_pct);
    int         done;
    int         pick;
    int         k;
    int         lo;
    int         cap;
    int         count;
    logic [7:0] tag;
    logic [7:0] size;
    logic [7:0] id;
    logic [7:0] route;
    logic [6:0] mlen;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < drain_pct) begin
        k = $urandom_range(0, 9);
        if (k == 0) mlen = 7'd0;
        else if (k == 1) mlen = 7'($urandom_range(65, 127));
        else if (k < 5) mlen = 7'($urandom_range(9, 64));
        else mlen = 7'($urandom_range(1, 8));
        send_drain(mlen);
        done++;
      end else if (pick < drain_pct + 6) begin
        send_byte(rnd8());
        done++;
      end else if (pick < drain_pct + 10) begin
        send_item(FUNC_NONE, rnd8(), rnd8(), rnd8(), rnd8(), 7'($urandom_range(0, 127)));
      end else if (pick < drain_pct + 16) begin
        send_item(func_t'($urandom_range(0, 2)), rnd8(), rnd8(), rnd8(), rnd8(),
                  7'($urandom_range(0, 127)));
        done++;
      end else begin
        // Tag: mostly one that routes into the queue.
        lo = int'(cfg_mirror[REG_LOCAL_END]) + 1;
        if (lo < int'(cfg_mirror[REG_LOCAL_START])) lo = int'(cfg_mirror[REG_LOCAL_START]);
        k = $urandom_range(0, 9);
        if (k < 7 && lo <= 255)
          tag = 8'($urandom_range(lo, 255));
        else if (k == 7 && cfg_mirror[REG_LOCAL_START] != 8'd0)
          tag = 8'($urandom_range(0, int'(cfg_mirror[REG_LOCAL_START]) - 1));
        else if (k == 8 && cfg_mirror[REG_LOCAL_START] <= cfg_mirror[REG_LOCAL_END])
          tag = 8'($urandom_range(cfg_mirror[REG_LOCAL_START], cfg_mirror[REG_LOCAL_END]));
        else
          tag = rnd8();
        // Size: mostly small, a few near the size limit.
        cap = int'(cfg_mirror[REG_MAX_MSG]);
        k = $urandom_range(0, 99);
        if (k < 70) size = 8'($urandom_range(0, (cap > 5) ? 4 : cap - 1));
        else if (k < 96) size = 8'($urandom_range(5, 20));
        else if (k < 99)
          size = 8'($urandom_range((cap > 3) ? cap - 3 : 0, (cap > 253) ? 255 : cap + 2));
        else size = rnd8();
        // Tag either as the id itself or carried in the route byte.
        if ($urandom_range(0, 4) == 0) begin
          id    = cfg_mirror[REG_INVALID_TAG];
          route = tag;
        end else begin
          id    = tag;
          route = rnd8();
        end
        // Now and then the frame is cut short or followed by extra bytes.
        count = int'(size);
        k = $urandom_range(0, 19);
        if (k == 0 && size > 8'd0) count = $urandom_range(0, int'(size) - 1);
        else if (k == 1) count = int'(size) + $urandom_range(1, 3);
        send_header(size, id, route);
        repeat (count) send_byte(rnd8());
        done += count + 1;
      end
    end
  endtask

  // Result side: random stalls, steady stretches and one long hold-off.
  initial begin : sink
    int n;
    int steady;
    m_tready = 1'b0;
    steady   = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_tready = 1'b1;
      end else if (quiet || steady > 0) begin
        m_tready = 1'b1;
        if (steady > 0) steady--;
      end else if ($urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 39) == 0) steady = $urandom_range(20, 80);
      end
    end
  end

  initial begin : stimulus
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = FUNC_HEADER;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LOCAL_START;
    cfg_data      = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    sender_steady = 0;
    cfg_mirror[REG_LOCAL_START] = RST_LOCAL_START;
    cfg_mirror[REG_LOCAL_END]   = RST_LOCAL_END;
    cfg_mirror[REG_UNRELIABLE]  = RST_UNRELIABLE;
    cfg_mirror[REG_INVALID_TAG] = RST_INVALID_TAG;
    cfg_mirror[REG_MAX_MSG]     = RST_MAX_MSG;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening under reset register values. A write to an index
    // past the last register must leave them untouched.
    write_reg(REG_SPARE, 8'hFF);
    send_drain(7'd5);                         // empty ring
    send_drain(7'd0);                         // zero-length drain
    send_byte(8'hFF);                         // no message open
    send_item(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F);
    send_header(8'd3, 8'd10, 8'd0);           // side path
    send_byte(8'hAA);                         // payload after side path
    send_header(8'd2, 8'd150, 8'd255);        // addressed to us, refused
    send_header(8'd127, 8'd176, 8'd0);        // one past the size limit
    send_header(8'd255, 8'd176, 8'd0);        // size plus one needs nine bits
    send_header(8'd0, 8'd255, 8'd200);        // tag from route byte, empty message
    send_header(8'd4, 8'd255, 8'd0);          // route byte tag on the side path
    send_header(8'd1, 8'd0, 8'd255);          // lowest id
    send_header(8'd2, 8'd200, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'd3, 8'd201, 8'd0);
    send_byte(8'h55);                         // frame left open ...
    send_header(8'd1, 8'd202, 8'd0);          // ... and abandoned here
    send_byte(8'h80);
    send_drain(7'd127);                       // clamped to the drain maximum
    send_drain(7'd3);
    settle();

    // Lowest range limits, every id unreliable, largest messages. The result
    // side holds off while one big frame fills most of the ring.
    load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd253);
    hold_req = 1'b1;
    send_header(8'd180, 8'd77, rnd8());
    repeat (180) send_byte(rnd8());
    run_traffic(30, 4);
    settle();

    // Only empty messages fit; nearly every id is reliable.
    load_regs(8'd64, 8'd100, 8'd255, 8'd128, 8'd1);
    run_traffic(25, 8);
    settle();

    // Range start above its end: only the top tag routes into the queue.
    load_regs(8'd255, 8'd254, 8'd128, 8'd7, 8'd40);
    run_traffic(30, 12);
    settle();

    // Back to reset values with no idling on either side.
    quiet = 1'b1;
    load_regs(RST_LOCAL_START, RST_LOCAL_END, RST_UNRELIABLE, RST_INVALID_TAG,
              RST_MAX_MSG);
    run_traffic(45, 15);
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb_framed_byte_ring_queue: done, clean");
    end else begin
      $display("tb_framed_byte_ring_queue: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_framed_byte_ring_queue: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fbrq_pkg.sv
rtl/core/fbrq_ctrl.sv
rtl/core/fbrq_dp.sv
rtl/core/framed_byte_ring_queue.sv
dv/fbrq_checker.sv
dv/tb_framed_byte_ring_queue.sv
